// File: design/lli_pkg.sv
// Shared constants and types for the table interpolator.
package lli_pkg;
    localparam int TableDepth   = 256;
    localparam int FractionBits = 16;
    localparam int DataWidth    = 32;
    localparam int WeightWidth  = 17;

    localparam logic [1:0] CmdClear = 2'd0;
    localparam logic [1:0] CmdLoad  = 2'd1;
    localparam logic [1:0] CmdQuery = 2'd2;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StEmpty = 2'd1;
    localparam logic [1:0] StFull  = 2'd2;
    localparam logic [1:0] StOrder = 2'd3;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SRCH  = 7'b0000010,
        S_SWAIT = 7'b0000100,
        S_RDLO  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;
endpackage

// File: design/lli_divider.sv
// Restoring divider, one quotient bit per cycle.
module lli_divider #(
    parameter int QW = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [QW-1:0] i_num,
    input  logic [31:0]   i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quo
);
    localparam int CW = $clog2(QW + 1);
    logic [QW-1:0] r_q;
    logic [32:0]   r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [32:0]   w_try;

    assign w_try  = {r_rem[31:0], r_q[QW-1]};
    assign o_quo  = r_q;
    assign o_done = r_busy && (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(QW);
            r_q    <= i_num;
            r_rem  <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
            if (w_try >= {1'b0, i_den}) begin
                r_rem <= w_try - {1'b0, i_den};
                r_q   <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_rem <= w_try;
                r_q   <= {r_q[QW-2:0], 1'b0};
            end
        end else if (r_busy) begin
            r_busy <= 1'b0;
        end
    end
endmodule

// File: design/lut_linear_interpolator.sv
// Clear, load, reserved commands and a query on an empty table give their result in the
// cycle after the transaction is accepted. A query inside the table runs a binary search in
// S_SRCH and S_SWAIT, then S_RDLO, S_DIV, S_MUL and S_OUT, and a query clamped to an end row
// runs the search and then goes to S_OUT.
// One transaction is in the block at a time; the next is accepted at the edge its result is taken.
// Reset is synchronous and active low; it empties the table, and table memory is not cleared.
module lut_linear_interpolator #(
    parameter int TABLE_DEPTH   = lli_pkg::TableDepth,
    parameter int FRACTION_BITS = lli_pkg::FractionBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_energy,
    input  logic signed [31:0] i_frequency_mean_in,
    input  logic signed [31:0] i_saturation_mean_in,
    input  logic signed [31:0] i_dose_mean_in,
    input  logic signed [31:0] i_frequency_error_in,
    input  logic signed [31:0] i_dose_error_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic signed [31:0] o_frequency_mean_out,
    output logic signed [31:0] o_saturation_mean_out,
    output logic signed [31:0] o_dose_mean_out,
    output logic signed [31:0] o_frequency_error_out,
    output logic signed [31:0] o_dose_error_out,
    output logic [31:0] o_lower_energy,
    output logic [31:0] o_upper_energy,
    output logic [16:0] o_lower_weight,
    output logic [16:0] o_upper_weight
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int QW = 32 + FRACTION_BITS;
    localparam int WW = FRACTION_BITS + 1;
    localparam logic [WW-1:0] One = WW'(1) << FRACTION_BITS;

    logic [31:0]  r_emem [TABLE_DEPTH];
    logic [159:0] r_vmem [TABLE_DEPTH];
    logic [31:0]  r_erd;
    logic [159:0] r_vrd;
    logic [AW-1:0] r_raddr;

    lli_pkg::t_state r_state;
    logic [CW-1:0] r_count, r_lo, r_hi;
    logic [31:0]   r_last, r_q, r_elo, r_ehi;
    logic [159:0]  r_vlo, r_vhi;
    logic [WW-1:0] r_wl, r_wu;
    logic [2:0]    r_k;
    logic [1:0]    r_ph;
    logic [63:0]   r_acc, r_prod;
    logic [159:0]  r_res;
    logic          r_div_start;
    logic          w_div_done;
    logic [QW-1:0] w_quo;
    logic          w_take;
    logic          w_quick;
    logic [CW-1:0] w_mid;
    logic [31:0]   w_opv;
    logic [WW-1:0] w_opw;

    assign o_stall = (r_state != lli_pkg::S_IDLE) || (o_valid && i_stall);
    assign w_take  = i_valid && !o_stall;
    // Every command except a query on a non-empty table answers in the next cycle.
    assign w_quick = (i_command != lli_pkg::CmdQuery) || (r_count == '0);
    assign w_mid   = CW'((32'(r_lo) + 32'(r_hi)) >> 1);

    lli_divider #(.QW(QW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_num({r_q - r_elo, FRACTION_BITS'(0)}), .i_den(r_ehi - r_elo),
        .o_done(w_div_done), .o_quo(w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (w_take && i_command == lli_pkg::CmdLoad && r_count < CW'(TABLE_DEPTH)
            && (r_count == '0 || i_energy > r_last)) begin
            r_emem[r_count[AW-1:0]] <= i_energy;
            r_vmem[r_count[AW-1:0]] <= {i_dose_error_in, i_frequency_error_in,
                i_dose_mean_in, i_saturation_mean_in, i_frequency_mean_in};
        end
        r_erd <= r_emem[r_raddr];
        r_vrd <= r_vmem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= (r_state == lli_pkg::S_RDLO) && (r_ph == 2'd3);
        end
    end

    // Operands flipped to offset binary so the unsigned blend floors correctly.
    assign w_opv = (r_ph == 2'd0 ? r_vlo[32*r_k +: 32] : r_vhi[32*r_k +: 32]) ^ 32'h8000_0000;
    assign w_opw = (r_ph == 2'd0) ? r_wl : r_wu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lli_pkg::S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && !(w_take && w_quick)) o_valid <= 1'b0;
            case (r_state)
                lli_pkg::S_IDLE: if (w_take) begin
                    o_frequency_mean_out <= '0; o_saturation_mean_out <= '0;
                    o_dose_mean_out <= '0; o_frequency_error_out <= '0;
                    o_dose_error_out <= '0; o_lower_energy <= '0;
                    o_upper_energy <= '0; o_lower_weight <= '0; o_upper_weight <= '0;
                    r_q <= i_energy;
                    case (i_command)
                        lli_pkg::CmdClear: begin
                            o_status <= lli_pkg::StOk;
                            r_count <= '0; o_valid <= 1'b1;
                        end
                        lli_pkg::CmdLoad: begin
                            o_valid <= 1'b1;
                            if (r_count >= CW'(TABLE_DEPTH)) o_status <= lli_pkg::StFull;
                            else if (r_count != '0 && i_energy <= r_last)
                                o_status <= lli_pkg::StOrder;
                            else begin
                                o_status <= lli_pkg::StOk;
                                r_count <= r_count + 1'b1; r_last <= i_energy;
                            end
                        end
                        lli_pkg::CmdQuery: begin
                            if (r_count == '0) begin
                                o_status <= lli_pkg::StEmpty; o_valid <= 1'b1;
                            end else begin
                                o_status <= lli_pkg::StOk;
                                r_lo <= '0; r_hi <= r_count; r_state <= lli_pkg::S_SRCH;
                            end
                        end
                        default: begin
                            o_status <= lli_pkg::StOk; o_valid <= 1'b1;
                        end
                    endcase
                end
                lli_pkg::S_SRCH: begin
                    if (r_lo == r_hi) begin
                        // r_lo is the first row not below the query.
                        if (r_lo == '0 || r_lo == r_count) begin
                            r_raddr <= (r_lo == '0) ? '0 : AW'(r_count - 1'b1);
                            r_wl <= One; r_wu <= '0; r_k <= 3'd7;
                        end else begin
                            r_raddr <= AW'(r_lo); r_k <= 3'd0;
                        end
                        r_state <= lli_pkg::S_SWAIT; r_ph <= 2'd0;
                    end else begin
                        r_raddr <= AW'(w_mid); r_ph <= 2'd1; r_state <= lli_pkg::S_SWAIT;
                    end
                end
                lli_pkg::S_SWAIT: begin
                    if (r_ph == 2'd1) r_ph <= 2'd2;
                    else if (r_ph == 2'd2) begin
                        if (r_erd < r_q) r_lo <= w_mid + 1'b1; else r_hi <= w_mid;
                        r_state <= lli_pkg::S_SRCH;
                    end else if (r_ph == 2'd0) r_ph <= 2'd3;
                    else begin
                        r_ehi <= r_erd; r_vhi <= r_vrd;
                        r_elo <= r_erd; r_vlo <= r_vrd;
                        if (r_k == 3'd7) begin
                            r_res <= r_vrd; r_state <= lli_pkg::S_OUT;
                        end else begin
                            r_raddr <= AW'(r_lo - 1'b1); r_ph <= 2'd0;
                            r_state <= lli_pkg::S_RDLO;
                        end
                    end
                end
                lli_pkg::S_RDLO: begin
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else if (r_ph == 2'd1) r_ph <= 2'd2;
                    else if (r_ph == 2'd2) begin
                        r_elo <= r_erd; r_vlo <= r_vrd; r_ph <= 2'd3;
                    end else begin
                        r_state <= lli_pkg::S_DIV;
                    end
                end
                lli_pkg::S_DIV: if (w_div_done) begin
                    r_wu <= (w_quo > QW'(One)) ? One : w_quo[WW-1:0];
                    r_wl <= One - ((w_quo > QW'(One)) ? One : w_quo[WW-1:0]);
                    r_k <= 3'd0; r_ph <= 2'd0; r_acc <= '0; r_state <= lli_pkg::S_MUL;
                end
                lli_pkg::S_MUL: begin
                    // Two products per value through one multiplier, then accumulate.
                    r_prod <= 64'(w_opv) * 64'(w_opw);
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else if (r_ph == 2'd1) begin
                        r_acc <= r_prod; r_ph <= 2'd2;
                    end else begin
                        r_res[32*r_k +: 32] <= 32'((r_acc + r_prod) >> FRACTION_BITS)
                            ^ 32'h8000_0000;
                        r_ph <= 2'd0;
                        if (r_k == 3'd4) r_state <= lli_pkg::S_OUT;
                        else r_k <= r_k + 1'b1;
                    end
                end
                lli_pkg::S_OUT: begin
                    o_frequency_mean_out  <= r_res[31:0];
                    o_saturation_mean_out <= r_res[63:32];
                    o_dose_mean_out       <= r_res[95:64];
                    o_frequency_error_out <= r_res[127:96];
                    o_dose_error_out      <= r_res[159:128];
                    o_lower_energy <= r_elo; o_upper_energy <= r_ehi;
                    o_lower_weight <= 17'(r_wl); o_upper_weight <= 17'(r_wu);
                    o_valid <= 1'b1; r_state <= lli_pkg::S_IDLE;
                end
                default: r_state <= lli_pkg::S_IDLE;
            endcase
        end
    end
endmodule

// File: design/lli_checker.sv
// Port-level checks for the table interpolator, bound to the top level.
module lli_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [16:0] o_lower_weight,
    input logic [16:0] o_upper_weight
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)) else $error("result dropped");
    a_wsum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == lli_pkg::StOk && (o_lower_weight | o_upper_weight) != 0
        |-> o_lower_weight + o_upper_weight == 17'h10000) else $error("weights");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall) else $error("accepts while result waits");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall || o_valid) else $error("no result");
endmodule

bind lut_linear_interpolator lli_port_checks u_chk (.*);
